[rtl/core/error_function_approx_top_macros.svh]
// Assertion macros used by the error function top level.
`ifndef ERROR_FUNCTION_APPROX_TOP_MACROS_SVH
`define ERROR_FUNCTION_APPROX_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define EFA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Next-cycle implication, checked out of reset.
`define EFA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`else
`define EFA_ASSERT_IMP(label, ante, cons)
`define EFA_ASSERT_NXT(label, ante, cons)
`endif

`endif

[rtl/core/efa_pkg.sv]
// Types and constants of the error function pipeline.
`timescale 1ns / 1ps
package efa_pkg;

	localparam int Z_W      = 20;
	localparam int T_W      = 31;
	localparam int ZSQ_W    = 37;
	localparam int ACC_W    = 34;
	localparam int E_W      = 39;
	localparam int REM_W    = 45;
	localparam int R_W      = 32;
	localparam int SUM_W    = 34;
	localparam int OUT_W    = 32;
	localparam int DIV_STAGES   = 8;
	localparam int DIV_BITS     = 4;
	localparam int DIV_Q_W      = 32;
	localparam int HORNER_STEPS = 9;
	localparam int RED_STEPS    = 5;
	localparam int TAYLOR_STEPS = 15;

	localparam logic [32:0]      NINE_Q16    = 33'd589824;
	localparam logic [Z_W-1:0]   D_BIAS      = 20'h20000;
	localparam logic [Z_W-1:0]   DIV_REM0    = 20'h08000;
	localparam logic [39:0]      LN2_Q40     = 40'hB17217F7D2;
	localparam logic [R_W-1:0]   LN2_Q32_MAX = 32'hB17217F7;
	localparam logic signed [34:0] ONE_Q30   = 35'sd1073741824;

	localparam longint DecScale = 64'sd1073741824;
	localparam longint DecRound = 64'sd50000000;
	localparam longint DecDiv   = 64'sd100000000;

	localparam logic [ACC_W-1:0] POLY_COEF [10] = '{
		ACC_W'(-((64'sd126551223 * DecScale + DecRound) / DecDiv)),
		ACC_W'( (64'sd100002368 * DecScale + DecRound) / DecDiv),
		ACC_W'( (64'sd37409196  * DecScale + DecRound) / DecDiv),
		ACC_W'( (64'sd9678418   * DecScale + DecRound) / DecDiv),
		ACC_W'(-((64'sd18628806  * DecScale + DecRound) / DecDiv)),
		ACC_W'( (64'sd27886807  * DecScale + DecRound) / DecDiv),
		ACC_W'(-((64'sd113520398 * DecScale + DecRound) / DecDiv)),
		ACC_W'( (64'sd148851587 * DecScale + DecRound) / DecDiv),
		ACC_W'(-((64'sd82215223  * DecScale + DecRound) / DecDiv)),
		ACC_W'( (64'sd17087277  * DecScale + DecRound) / DecDiv)
	};

	localparam longint Two32 = 64'sd4294967296;

	// floor(2^32 / k) for the series divisors k = 2 .. 16
	localparam logic [31:0] TAYLOR_RECIP [TAYLOR_STEPS] = '{
		32'(Two32 / 2),  32'(Two32 / 3),  32'(Two32 / 4),  32'(Two32 / 5),
		32'(Two32 / 6),  32'(Two32 / 7),  32'(Two32 / 8),  32'(Two32 / 9),
		32'(Two32 / 10), 32'(Two32 / 11), 32'(Two32 / 12), 32'(Two32 / 13),
		32'(Two32 / 14), 32'(Two32 / 15), 32'(Two32 / 16)
	};

	typedef struct packed {
		logic             neg;
		logic             inr;
		logic [ZSQ_W-1:0] zsq;
	} side_t;

	typedef struct packed {
		logic           neg;
		logic           inr;
		logic           zero;
		logic [4:0]     shift;
		logic [T_W-1:0] t;
	} tail_t;

endpackage

[rtl/core/efa_div.sv]
// Pipelined restoring divider producing t = round(2^47 / d).
`timescale 1ns / 1ps
module efa_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_v,
	input  logic [efa_pkg::Z_W-1:0] d,
	input  efa_pkg::side_t         side_i,
	output logic                   out_v,
	output logic [efa_pkg::T_W-1:0] quo,
	output efa_pkg::side_t         side_o
);

	typedef struct packed {
		logic [efa_pkg::Z_W-1:0]     rem;
		logic [efa_pkg::DIV_Q_W-1:0] num;
		logic [efa_pkg::DIV_Q_W-1:0] q;
		logic [efa_pkg::Z_W-1:0]     d;
		efa_pkg::side_t              side;
	} div_t;

	function automatic div_t div_step(div_t c);
		div_t n;
		logic [efa_pkg::Z_W:0] tr;
		n = c;
		for (int i = 0; i < efa_pkg::DIV_BITS; i++) begin
			tr    = {n.rem, n.num[efa_pkg::DIV_Q_W-1]};
			n.num = {n.num[efa_pkg::DIV_Q_W-2:0], 1'b0};
			if (tr >= {1'b0, n.d}) begin
				n.rem = efa_pkg::Z_W'(tr - {1'b0, n.d});
				n.q   = {n.q[efa_pkg::DIV_Q_W-2:0], 1'b1};
			end else begin
				n.rem = tr[efa_pkg::Z_W-1:0];
				n.q   = {n.q[efa_pkg::DIV_Q_W-2:0], 1'b0};
			end
		end
		return n;
	endfunction

	div_t                              stg_in;
	div_t                              div_s [efa_pkg::DIV_STAGES];
	logic [efa_pkg::DIV_STAGES-1:0]    v_s;

	// numerator is 2^47 + d/2: top word seeds the remainder, low word shifts in
	always_comb begin
		stg_in.rem  = efa_pkg::DIV_REM0;
		stg_in.num  = {{(efa_pkg::DIV_Q_W-efa_pkg::Z_W+1){1'b0}}, d[efa_pkg::Z_W-1:1]};
		stg_in.q    = '0;
		stg_in.d    = d;
		stg_in.side = side_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[efa_pkg::DIV_STAGES-2:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= div_step(stg_in);
			for (int k = 1; k < efa_pkg::DIV_STAGES; k++)
				div_s[k] <= div_step(div_s[k-1]);
		end
	end

	assign out_v  = v_s[efa_pkg::DIV_STAGES-1];
	assign quo    = div_s[efa_pkg::DIV_STAGES-1].q[efa_pkg::T_W-1:0];
	assign side_o = div_s[efa_pkg::DIV_STAGES-1].side;

endmodule

[rtl/core/efa_horner.sv]
// Horner evaluation of the ten-term polynomial P(t), two stages a step.
`timescale 1ns / 1ps
module efa_horner (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_v,
	input  logic [efa_pkg::T_W-1:0]  t,
	input  efa_pkg::side_t           side_i,
	output logic                     out_v,
	output logic [efa_pkg::ACC_W-1:0] acc,
	output logic [efa_pkg::T_W-1:0]  t_o,
	output efa_pkg::side_t           side_o
);

	localparam int N = efa_pkg::HORNER_STEPS;

	typedef struct packed {
		logic [efa_pkg::ACC_W-1:0] acc;
		logic [efa_pkg::T_W-1:0]   t;
		efa_pkg::side_t            side;
	} hacc_t;

	typedef struct packed {
		logic                    neg;
		logic [63:0]             prod;
		logic [efa_pkg::T_W-1:0] t;
		efa_pkg::side_t          side;
	} hmul_t;

	function automatic hmul_t h_mul(hacc_t c);
		hmul_t n;
		logic [efa_pkg::ACC_W-1:0] nacc;
		logic [efa_pkg::ACC_W-2:0] mag;
		nacc   = -c.acc;
		n.neg  = c.acc[efa_pkg::ACC_W-1];
		mag    = n.neg ? nacc[efa_pkg::ACC_W-2:0] : c.acc[efa_pkg::ACC_W-2:0];
		n.prod = 64'(mag) * 64'(c.t);
		n.t    = c.t;
		n.side = c.side;
		return n;
	endfunction

	// round half away from zero, then add the next coefficient
	function automatic hacc_t h_add(hmul_t c, logic [efa_pkg::ACC_W-1:0] coef);
		hacc_t n;
		logic [63:0] rnd;
		logic [efa_pkg::ACC_W-1:0] p;
		rnd    = c.prod + 64'd536870912;
		p      = rnd[63:30];
		n.acc  = c.neg ? coef - p : coef + p;
		n.t    = c.t;
		n.side = c.side;
		return n;
	endfunction

	hacc_t          seed;
	hmul_t          hm_s [N];
	hacc_t          ha_s [N];
	logic [N-1:0]   vm_s;
	logic [N-1:0]   va_s;

	always_comb begin
		seed.acc  = efa_pkg::POLY_COEF[N];
		seed.t    = t;
		seed.side = side_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vm_s <= '0;
			va_s <= '0;
		end else if (en) begin
			vm_s <= {va_s[N-2:0], in_v};
			va_s <= vm_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hm_s[0] <= h_mul(seed);
			for (int j = 1; j < N; j++)
				hm_s[j] <= h_mul(ha_s[j-1]);
			for (int j = 0; j < N; j++)
				ha_s[j] <= h_add(hm_s[j], efa_pkg::POLY_COEF[N-1-j]);
		end
	end

	assign out_v  = va_s[N-1];
	assign acc    = ha_s[N-1].acc;
	assign t_o    = ha_s[N-1].t;
	assign side_o = ha_s[N-1].side;

endmodule

[rtl/core/efa_expred.sv]
// Exponent e = P - z*z split into r - s*ln2 by a five-step constant divider.
`timescale 1ns / 1ps
module efa_expred (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_v,
	input  logic [efa_pkg::ACC_W-1:0] acc,
	input  logic [efa_pkg::T_W-1:0]   t,
	input  efa_pkg::side_t            side_i,
	output logic                      out_v,
	output logic [efa_pkg::R_W-1:0]   r,
	output efa_pkg::tail_t            tail_o
);

	localparam int N = efa_pkg::RED_STEPS;

	typedef struct packed {
		logic [efa_pkg::REM_W-1:0] rem;
		logic [N-1:0]              q;
		logic                      epos;
		logic                      big;
		logic [efa_pkg::R_W-1:0]   rpos;
		efa_pkg::tail_t            tl;
	} xr_t;

	function automatic xr_t red_step(xr_t c, int b);
		xr_t n;
		logic [efa_pkg::REM_W-1:0] sub;
		n   = c;
		sub = efa_pkg::REM_W'(efa_pkg::LN2_Q40) << b;
		if (c.rem >= sub) begin
			n.rem  = c.rem - sub;
			n.q[b] = 1'b1;
		end
		return n;
	endfunction

	logic [efa_pkg::E_W-1:0] e_s1;
	logic [efa_pkg::T_W-1:0] t_s1;
	logic                    neg_s1;
	logic                    inr_s1;
	xr_t                     x_s2;
	xr_t                     red_s [N];
	logic [efa_pkg::R_W-1:0] r_s3;
	efa_pkg::tail_t          tail_s3;
	logic                    v_s1;
	logic                    v_s2;
	logic [N-1:0]            vr_s;
	logic                    v_s3;

	logic [efa_pkg::E_W-1:0] e_neg;
	logic [48:0]             m40;
	logic [40:0]             e4;
	xr_t                     x_nx;
	xr_t                     last;
	logic                    is0;
	logic [5:0]              sh6;
	logic [39:0]             r40;
	logic [40:0]             r40_rnd;
	logic [efa_pkg::R_W-1:0] r_nx;
	efa_pkg::tail_t          tail_nx;

	// magnitude, underflow test and the non-negative clamp
	always_comb begin
		e_neg         = -e_s1;
		m40           = {e_neg, 10'b0};
		e4            = {e_s1, 2'b00};
		x_nx.epos     = !e_s1[efa_pkg::E_W-1];
		x_nx.big      = m40 >= (49'(efa_pkg::LN2_Q40) << N);
		x_nx.rem      = m40[efa_pkg::REM_W-1:0];
		x_nx.q        = '0;
		x_nx.rpos     = (e4 > 41'(efa_pkg::LN2_Q32_MAX)) ? efa_pkg::LN2_Q32_MAX :
		                e4[efa_pkg::R_W-1:0];
		x_nx.tl.neg   = neg_s1;
		x_nx.tl.inr   = inr_s1;
		x_nx.tl.zero  = 1'b0;
		x_nx.tl.shift = '0;
		x_nx.tl.t     = t_s1;
	end

	// round the residue up to the next multiple of ln2; non-negative e keeps rpos
	always_comb begin
		last    = red_s[N-1];
		is0     = last.rem == '0;
		sh6     = is0 ? {1'b0, last.q} : {1'b0, last.q} + 6'd1;
		r40     = is0 ? 40'd0 : efa_pkg::LN2_Q40 - last.rem[39:0];
		r40_rnd = {1'b0, r40} + 41'd128;
		tail_nx = last.tl;
		if (last.epos) begin
			r_nx          = last.rpos;
			tail_nx.shift = '0;
			tail_nx.zero  = 1'b0;
		end else begin
			r_nx          = r40_rnd[39:8];
			tail_nx.shift = sh6[4:0];
			tail_nx.zero  = last.big | sh6[5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vr_s <= '0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			vr_s <= {vr_s[N-2:0], v_s2};
			v_s3 <= vr_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1   <= {{(efa_pkg::E_W-efa_pkg::ACC_W){acc[efa_pkg::ACC_W-1]}}, acc}
			          - {{(efa_pkg::E_W-efa_pkg::ZSQ_W){1'b0}}, side_i.zsq};
			t_s1   <= t;
			neg_s1 <= side_i.neg;
			inr_s1 <= side_i.inr;
			x_s2   <= x_nx;
			red_s[0] <= red_step(x_s2, N-1);
			for (int j = 1; j < N; j++)
				red_s[j] <= red_step(red_s[j-1], N-1-j);
			r_s3    <= r_nx;
			tail_s3 <= tail_nx;
		end
	end

	assign out_v  = v_s3;
	assign r      = r_s3;
	assign tail_o = tail_s3;

endmodule

[rtl/core/efa_taylor.sv]
// Series 1 + r + ... + r^16/16! for exp(r), three stages per added term.
`timescale 1ns / 1ps
module efa_taylor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_v,
	input  logic [efa_pkg::R_W-1:0]   r,
	input  efa_pkg::tail_t            tail_i,
	output logic                      out_v,
	output logic [efa_pkg::SUM_W-1:0] sum,
	output efa_pkg::tail_t            tail_o
);

	localparam int N = efa_pkg::TAYLOR_STEPS;

	typedef struct packed {
		logic [efa_pkg::R_W-1:0]   term;
		logic [efa_pkg::SUM_W-1:0] sum;
		logic [efa_pkg::R_W-1:0]   r;
		efa_pkg::tail_t            tl;
	} tc_t;

	typedef struct packed {
		logic [63:0]               prod;
		logic [efa_pkg::SUM_W-1:0] sum;
		logic [efa_pkg::R_W-1:0]   r;
		efa_pkg::tail_t            tl;
	} ta_t;

	typedef struct packed {
		logic [efa_pkg::R_W-1:0]   t2;
		logic [63:0]               qmul;
		logic [efa_pkg::SUM_W-1:0] sum;
		logic [efa_pkg::R_W-1:0]   r;
		efa_pkg::tail_t            tl;
	} tb_t;

	function automatic ta_t tay_a(tc_t c);
		ta_t n;
		n.prod = 64'(c.term) * 64'(c.r);
		n.sum  = c.sum;
		n.r    = c.r;
		n.tl   = c.tl;
		return n;
	endfunction

	function automatic tb_t tay_b(ta_t c, int j);
		tb_t n;
		n.t2   = c.prod[63:32];
		n.qmul = 64'(c.prod[63:32]) * 64'(efa_pkg::TAYLOR_RECIP[j]);
		n.sum  = c.sum;
		n.r    = c.r;
		n.tl   = c.tl;
		return n;
	endfunction

	// reciprocal estimate is low by at most one: fix it with one compare
	function automatic tc_t tay_c(tb_t c, int k);
		tc_t n;
		logic [31:0] q0;
		logic [35:0] qk;
		logic [35:0] rem;
		logic [31:0] q;
		q0     = c.qmul[63:32];
		qk     = 36'(q0) * 36'(k);
		rem    = 36'(c.t2) - qk;
		q      = (rem >= 36'(k)) ? q0 + 32'd1 : q0;
		n.term = q;
		n.sum  = c.sum + efa_pkg::SUM_W'(q);
		n.r    = c.r;
		n.tl   = c.tl;
		return n;
	endfunction

	tc_t          seed;
	ta_t          ta_s [N];
	tb_t          tb_s [N];
	tc_t          tc_s [N];
	logic [N-1:0] va_s;
	logic [N-1:0] vb_s;
	logic [N-1:0] vc_s;

	always_comb begin
		seed.term = r;
		seed.sum  = {2'b01, r};
		seed.r    = r;
		seed.tl   = tail_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s <= '0;
			vb_s <= '0;
			vc_s <= '0;
		end else if (en) begin
			va_s <= {vc_s[N-2:0], in_v};
			vb_s <= va_s;
			vc_s <= vb_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s[0] <= tay_a(seed);
			for (int j = 1; j < N; j++)
				ta_s[j] <= tay_a(tc_s[j-1]);
			for (int j = 0; j < N; j++) begin
				tb_s[j] <= tay_b(ta_s[j], j);
				tc_s[j] <= tay_c(tb_s[j], j + 2);
			end
		end
	end

	assign out_v  = vc_s[N-1];
	assign sum    = tc_s[N-1].sum;
	assign tail_o = tc_s[N-1].tl;

endmodule

[rtl/core/error_function_approx_top.sv]
// Top level of the fixed-point error function pipeline with output skid.
// The pipe is 85 register stages deep, from the first front stage to the output register.
// Throughput: one word per cycle; input stalls only while the output skid register is full.
// Depth is set by the 32-bit divider, the Horner chain, the range reduction and the series terms.
// Reset clears every valid bit and the output and skid flags; data registers keep no reset.
`timescale 1ns / 1ps
`include "error_function_approx_top_macros.svh"
module error_function_approx_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              x_valid,
	output logic              x_ready,
	input  logic signed [31:0] arg_x,
	output logic              erf_valid,
	input  logic              erf_ready,
	output logic signed [31:0] erf_value
);

	// global advance: every stage moves while the skid register is free
	logic en;

	// front: |x|, range flags, then z*z and the divisor
	logic                              v_s1;
	logic                              neg_s1;
	logic                              inr_s1;
	logic [efa_pkg::Z_W-1:0]           z_s1;
	logic                              v_s2;
	logic [efa_pkg::Z_W-1:0]           d_s2;
	efa_pkg::side_t                    side_s2;

	logic [32:0] z33;
	logic [39:0] zz;

	logic                              div_v;
	logic [efa_pkg::T_W-1:0]           div_t_w;
	efa_pkg::side_t                    div_side;
	logic                              hor_v;
	logic [efa_pkg::ACC_W-1:0]         hor_acc;
	logic [efa_pkg::T_W-1:0]           hor_t;
	efa_pkg::side_t                    hor_side;
	logic                              red_v;
	logic [efa_pkg::R_W-1:0]           red_r;
	efa_pkg::tail_t                    red_tail;
	logic                              tay_v;
	logic [efa_pkg::SUM_W-1:0]         tay_sum;
	efa_pkg::tail_t                    tay_tail;

	// back: t*exp(r), scaling by 2^-(32+s), reflection and clamp
	logic                              v_s3;
	logic [63:0]                       p_s3;
	efa_pkg::tail_t                    tail_s3;
	logic                              v_s4;
	logic [32:0]                       ec_s4;
	efa_pkg::tail_t                    tail_s4;
	logic                              v_s5;
	logic [efa_pkg::OUT_W-1:0]         res_s5;

	logic [64:0] rnd;
	logic [64:0] scl;
	logic signed [34:0] ec;
	logic signed [34:0] res_full;
	logic [efa_pkg::OUT_W-1:0] res_nx;

	// output register and skid
	logic                      erf_valid_q;
	logic [efa_pkg::OUT_W-1:0] erf_value_q;
	logic                      skid_v_q;
	logic [efa_pkg::OUT_W-1:0] skid_q;
	logic                      pass;

	assign en      = !skid_v_q;
	assign x_ready = en;
	assign pass    = v_s5 && en;

	always_comb begin
		z33 = arg_x[31] ? (33'h1_0000_0000 - {1'b0, arg_x}) : {1'b0, arg_x};
		zz  = 40'(z_s1) * 40'(z_s1) + 40'd2;
	end

	// round half up at bit 31+s, then drop 32+s bits
	always_comb begin
		rnd = {1'b0, p_s3} + (65'd1 << (7'(tail_s3.shift) + 7'd31));
		scl = rnd >> (7'(tail_s3.shift) + 7'd32);
	end

	// reflect for negative x, keep the result inside [-1, +1]
	always_comb begin
		ec       = tail_s4.zero ? 35'sd0 : $signed({2'b00, ec_s4});
		res_full = tail_s4.neg ? ec - efa_pkg::ONE_Q30 : efa_pkg::ONE_Q30 - ec;
		if (!tail_s4.inr) begin
			res_nx = tail_s4.neg ? efa_pkg::OUT_W'(-efa_pkg::ONE_Q30) :
			         efa_pkg::OUT_W'(efa_pkg::ONE_Q30);
		end else if (res_full > efa_pkg::ONE_Q30) begin
			res_nx = efa_pkg::OUT_W'(efa_pkg::ONE_Q30);
		end else if (res_full < -efa_pkg::ONE_Q30) begin
			res_nx = efa_pkg::OUT_W'(-efa_pkg::ONE_Q30);
		end else begin
			res_nx = res_full[efa_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= x_valid;
			v_s2 <= v_s1;
			v_s3 <= tay_v;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1       <= arg_x[31];
			inr_s1       <= z33 < efa_pkg::NINE_Q16;
			z_s1         <= z33[efa_pkg::Z_W-1:0];
			d_s2         <= z_s1 + efa_pkg::D_BIAS;
			side_s2.neg  <= neg_s1;
			side_s2.inr  <= inr_s1;
			side_s2.zsq  <= zz[efa_pkg::ZSQ_W+1:2];
			p_s3         <= 64'(tay_tail.t) * 64'(tay_sum);
			tail_s3      <= tay_tail;
			ec_s4        <= scl[32:0];
			tail_s4      <= tail_s3;
			res_s5       <= res_nx;
		end
	end

	// hold a word in the skid register while the output is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erf_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (!erf_valid_q || erf_ready) begin
			if (skid_v_q) begin
				erf_valid_q <= 1'b1;
				skid_v_q    <= 1'b0;
			end else begin
				erf_valid_q <= pass;
			end
		end else if (pass) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!erf_valid_q || erf_ready) begin
			if (skid_v_q) begin
				erf_value_q <= skid_q;
			end else if (pass) begin
				erf_value_q <= res_s5;
			end
		end else if (pass) begin
			skid_q <= res_s5;
		end
	end

	assign erf_valid = erf_valid_q;
	assign erf_value = erf_value_q;

	efa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s2),
		.d      (d_s2),
		.side_i (side_s2),
		.out_v  (div_v),
		.quo    (div_t_w),
		.side_o (div_side)
	);

	efa_horner u_horner (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (div_v),
		.t      (div_t_w),
		.side_i (div_side),
		.out_v  (hor_v),
		.acc    (hor_acc),
		.t_o    (hor_t),
		.side_o (hor_side)
	);

	efa_expred u_expred (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (hor_v),
		.acc    (hor_acc),
		.t      (hor_t),
		.side_i (hor_side),
		.out_v  (red_v),
		.r      (red_r),
		.tail_o (red_tail)
	);

	efa_taylor u_taylor (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (red_v),
		.r      (red_r),
		.tail_i (red_tail),
		.out_v  (tay_v),
		.sum    (tay_sum),
		.tail_o (tay_tail)
	);

	// a full skid register always sits behind a valid output word
	`EFA_ASSERT_IMP(a_skid_behind_out, skid_v_q, erf_valid_q)
	// a word leaving the pipe into a stalled output lands in the skid
	`EFA_ASSERT_NXT(a_skid_catch, erf_valid_q && !erf_ready && pass, skid_v_q)
	// the skid drains as soon as the output is taken
	`EFA_ASSERT_NXT(a_skid_drain, skid_v_q && erf_ready, !skid_v_q)
	// the clamped result never leaves [-1, +1]
	`EFA_ASSERT_IMP(a_res_range, v_s5,
		($signed(res_s5) <= 32'sd1073741824) && ($signed(res_s5) >= -32'sd1073741824))

endmodule
